@@ sv/rse_pkg.sv @@
package rse_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int ST_W   = 3;
  localparam int ITER_W = 5;

  localparam logic [ITER_W-1:0] ITER_LAST = 5'd31;

  localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_FEW      = 3'd1;
  localparam logic [ST_W-1:0] ST_DIVZERO  = 3'd2;
  localparam logic [ST_W-1:0] ST_DEPTH    = 3'd3;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ_Y,
    S_READ_X,
    S_ITER,
    S_WRITE,
    S_END
  } state_t;

endpackage

@@ sv/rpn_stack_evaluator.sv @@
// Postfix expression evaluator. Each input beat is one token: a signed 32-bit number to push
// (op 0) or add, subtract, multiply or divide (op 1 to 4), which pops two entries and pushes
// "first op second" with 32-bit wraparound, division truncating toward zero. A beat with last
// set ends the expression: one output beat carries the remaining value and a status (ok, too
// few operands, divide by zero, final depth not one, overflow); the first error of an
// expression sticks, and stack and error clear for the next expression. Tokens are taken one
// at a time and in_stall stays high while a token is in work. A push or an ignored op code
// is done at decode; add and subtract read both operands, add and write back; multiply and
// divide run one bit per cycle in between through a single shared 33-bit adder (shift-add
// multiply, restoring divide). An operator with too few operands, or any token after an
// error in the same expression, stops at decode, and a divide by zero once its operands
// are read. The operand stack is a memory with one write port and one registered read
// port, so an operator fetches its operands one after the other.
// No clearing pass runs after reset. A finished result waits in the output register while
// the next tokens are taken; only a later last token waits for it to leave.
module rpn_stack_evaluator #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic        [rse_pkg::OP_W-1:0]    op,
  input  logic signed [rse_pkg::DATA_W-1:0]  value,
  input  logic                               last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [rse_pkg::DATA_W-1:0]  answer,
  output logic        [rse_pkg::ST_W-1:0]    status
);
  import rse_pkg::*;

  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  state_t state, state_next;

  logic [CNT_W-1:0]  count, count_next;
  logic [ST_W-1:0]   err, err_next;
  logic [OP_W-1:0]   tok_op, tok_op_next;
  logic [DATA_W-1:0] tok_value, tok_value_next;
  logic              tok_last, tok_last_next;
  logic [DATA_W-1:0] top_val, top_val_next;
  logic [DATA_W-1:0] acc, acc_next;
  logic [DATA_W-1:0] opa, opa_next;
  logic [DATA_W-1:0] opb, opb_next;
  logic              neg, neg_next;
  logic [ITER_W-1:0] iter, iter_next;
  logic [DATA_W-1:0] bottom, bottom_next;
  logic              out_valid_next;
  logic [DATA_W-1:0] answer_next;
  logic [ST_W-1:0]   status_next;

  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [IDX_W-1:0]  mem_raddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [DATA_W-1:0] rd_data;

  logic [DATA_W-1:0] unit_a;
  logic [DATA_W-1:0] unit_b;
  logic              unit_sub;
  logic [DATA_W:0]   unit_sum;

  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_m2;
  logic [DATA_W-1:0] op_result;
  logic [ST_W-1:0]   final_status;

  assign in_stall = (state != S_IDLE);
  assign cnt_m1   = count - CNT_W'(1);
  assign cnt_m2   = count - CNT_W'(2);

  // shared adder: add, subtract, multiply step, divide trial subtract
  always_comb begin
    unit_a   = acc;
    unit_b   = opa;
    unit_sub = 1'b0;
    unique case (state)
      S_READ_X: begin
        unit_a   = rd_data;
        unit_b   = top_val;
        unit_sub = (tok_op == OP_SUB);
      end
      S_ITER: begin
        if (tok_op == OP_MUL) begin
          unit_a   = acc;
          unit_b   = opa;
          unit_sub = 1'b0;
        end else begin
          unit_a   = {acc[DATA_W-2:0], opa[DATA_W-1]};
          unit_b   = opb;
          unit_sub = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign unit_sum = {1'b0, unit_a} + {1'b0, (unit_sub ? ~unit_b : unit_b)}
                    + {{DATA_W{1'b0}}, unit_sub};

  assign op_result = (tok_op == OP_DIV) ? (neg ? (~opa) + DATA_W'(1) : opa) : acc;

  assign final_status = (err != ST_OK) ? err :
                        ((count != CNT_W'(1)) ? ST_DEPTH : ST_OK);

  always_comb begin
    state_next     = state;
    count_next     = count;
    err_next       = err;
    tok_op_next    = tok_op;
    tok_value_next = tok_value;
    tok_last_next  = tok_last;
    top_val_next   = top_val;
    acc_next       = acc;
    opa_next       = opa;
    opb_next       = opb;
    neg_next       = neg;
    iter_next      = iter;
    bottom_next    = bottom;
    answer_next    = answer;
    status_next    = status;
    out_valid_next = out_valid && out_stall;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_raddr      = '0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          tok_op_next    = op;
          tok_value_next = value;
          tok_last_next  = last;
          state_next     = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (err != ST_OK) begin
          state_next = S_END;
        end else if (tok_op == OP_PUSH) begin
          if (count >= CNT_W'(STACK_DEPTH)) begin
            err_next = ST_OVERFLOW;
          end else begin
            mem_we     = 1'b1;
            mem_waddr  = count[IDX_W-1:0];
            mem_wdata  = tok_value;
            count_next = count + CNT_W'(1);
            if (count == '0) begin
              bottom_next = tok_value;
            end
          end
          state_next = S_END;
        end else if (tok_op > OP_DIV) begin
          state_next = S_END;
        end else if (count < CNT_W'(2)) begin
          err_next   = ST_FEW;
          state_next = S_END;
        end else begin
          mem_raddr  = cnt_m1[IDX_W-1:0];
          state_next = S_READ_Y;
        end
      end
      S_READ_Y: begin
        top_val_next = rd_data;
        mem_raddr    = cnt_m2[IDX_W-1:0];
        state_next   = S_READ_X;
      end
      S_READ_X: begin
        unique case (tok_op)
          OP_ADD, OP_SUB: begin
            acc_next   = unit_sum[DATA_W-1:0];
            state_next = S_WRITE;
          end
          OP_MUL: begin
            acc_next   = '0;
            opa_next   = rd_data;
            opb_next   = top_val;
            iter_next  = '0;
            state_next = S_ITER;
          end
          OP_DIV: begin
            if (top_val == '0) begin
              err_next   = ST_DIVZERO;
              state_next = S_END;
            end else begin
              acc_next   = '0;
              opa_next   = rd_data[DATA_W-1] ? (~rd_data) + DATA_W'(1) : rd_data;
              opb_next   = top_val[DATA_W-1] ? (~top_val) + DATA_W'(1) : top_val;
              neg_next   = rd_data[DATA_W-1] ^ top_val[DATA_W-1];
              iter_next  = '0;
              state_next = S_ITER;
            end
          end
          default: begin
            state_next = S_END;
          end
        endcase
      end
      S_ITER: begin
        if (tok_op == OP_MUL) begin
          if (opb[0]) begin
            acc_next = unit_sum[DATA_W-1:0];
          end
          opa_next = {opa[DATA_W-2:0], 1'b0};
          opb_next = {1'b0, opb[DATA_W-1:1]};
        end else begin
          // restoring step: keep the difference when there is no borrow
          acc_next = unit_sum[DATA_W] ? unit_sum[DATA_W-1:0] : unit_a;
          opa_next = {opa[DATA_W-2:0], unit_sum[DATA_W]};
        end
        iter_next = iter + ITER_W'(1);
        if (iter == ITER_LAST) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        mem_we     = 1'b1;
        mem_waddr  = cnt_m2[IDX_W-1:0];
        mem_wdata  = op_result;
        count_next = cnt_m1;
        if (cnt_m2 == '0) begin
          bottom_next = op_result;
        end
        state_next = S_END;
      end
      S_END: begin
        if (!tok_last) begin
          state_next = S_IDLE;
        end else if (!(out_valid && out_stall)) begin
          out_valid_next = 1'b1;
          status_next    = final_status;
          answer_next    = (final_status == ST_OK) ? $signed(bottom) : '0;
          count_next     = '0;
          err_next       = ST_OK;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      err       <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      count     <= count_next;
      err       <= err_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    tok_op    <= tok_op_next;
    tok_value <= tok_value_next;
    tok_last  <= tok_last_next;
    top_val   <= top_val_next;
    acc       <= acc_next;
    opa       <= opa_next;
    opb       <= opb_next;
    neg       <= neg_next;
    iter      <= iter_next;
    bottom    <= bottom_next;
    answer    <= answer_next;
    status    <= status_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= stack_mem[mem_raddr];
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack count above depth");

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (err != ST_OK && state != S_END) |=> err == $past(err))
    else $error("error code changed inside an expression");

  a_end_emits: assert property (@(posedge clk) disable iff (rst)
    (state == S_END && tok_last && !(out_valid && out_stall)) |=> out_valid)
    else $error("last token gave no result");

  a_err_answer: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> answer == '0)
    else $error("nonzero answer with error status");

  a_iter_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_ITER && iter == ITER_LAST) |=> state == S_WRITE)
    else $error("iteration did not finish into write");

endmodule

@@ tb/rpn_stack_evaluator_tb.sv @@
module rpn_stack_evaluator_tb;
  import rse_pkg::*;

  localparam int DEPTH = 16;
  localparam logic [DATA_W-1:0] MAX_POS = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] MIN_NEG = 32'h8000_0000;
  localparam logic [DATA_W-1:0] MINUS_ONE = 32'hffff_ffff;
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;
  localparam int LONG_HOLD_CYCLES = 400;

  typedef struct packed {
    logic [DATA_W-1:0] answer;
    logic [ST_W-1:0]   status;
  } result_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic        [OP_W-1:0]   op;
  logic signed [DATA_W-1:0] value;
  logic                     last;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] answer;
  logic        [ST_W-1:0]   status;

  rpn_stack_evaluator uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .value     (value),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .answer    (answer),
    .status    (status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // expression state as the block should hold it
  logic [DATA_W-1:0] operand_model [DEPTH];
  int                model_depth = 0;
  logic [ST_W-1:0]   model_error = ST_OK;
  result_t           expected_results [$];

  int fail_count = 0;
  int tokens_sent = 0;
  int results_seen = 0;
  int status_hits [5] = '{default: 0};
  bit sender_gaps = 1'b0;
  bit sink_stalls = 1'b0;
  bit long_hold = 1'b0;

  function automatic logic [DATA_W-1:0] quotient_toward_zero(logic [DATA_W-1:0] a,
                                                              logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] ma, mb, q;
    ma = a[DATA_W-1] ? -a : a;
    mb = b[DATA_W-1] ? -b : b;
    q = ma / mb;
    return (a[DATA_W-1] ^ b[DATA_W-1]) ? -q : q;
  endfunction

  function automatic void evaluate_token(logic [OP_W-1:0] t_op, logic [DATA_W-1:0] t_val,
                                         logic t_last);
    logic [DATA_W-1:0] x, y, r;
    result_t res;
    r = '0;
    if (model_error == ST_OK) begin
      if (t_op == OP_PUSH) begin
        if (model_depth >= DEPTH) begin
          model_error = ST_OVERFLOW;
        end else begin
          operand_model[model_depth] = t_val;
          model_depth++;
        end
      end else if (t_op <= OP_DIV) begin
        if (model_depth < 2) begin
          model_error = ST_FEW;
        end else begin
          y = operand_model[model_depth-1];
          x = operand_model[model_depth-2];
          model_depth -= 2;
          case (t_op)
            OP_ADD: r = x + y;
            OP_SUB: r = x - y;
            OP_MUL: r = x * y;
            default: begin
              if (y == '0) model_error = ST_DIVZERO;
              else r = quotient_toward_zero(x, y);
            end
          endcase
          if (model_error == ST_OK) begin
            operand_model[model_depth] = r;
            model_depth++;
          end
        end
      end
    end
    if (t_last) begin
      res.status = model_error;
      if (res.status == ST_OK && model_depth != 1) res.status = ST_DEPTH;
      res.answer = (res.status == ST_OK) ? operand_model[0] : '0;
      expected_results.push_back(res);
      model_depth = 0;
      model_error = ST_OK;
    end
  endfunction

  always @(posedge clk) begin : monitor
    result_t exp_r;
    if (!rst) begin
      if (in_valid && !in_stall) evaluate_token(op, value, last);
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result beat: answer %0d status %0d", answer, status);
        end else begin
          exp_r = expected_results.pop_front();
          status_hits[exp_r.status]++;
          if (answer !== exp_r.answer || status !== exp_r.status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch: expected answer %0d status %0d, got answer %0d status %0d",
                       $signed(exp_r.answer), exp_r.status, answer, status);
          end
        end
      end
    end
  end

  // result side stall
  initial begin : sink
    int hold;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        for (hold = 0; hold < LONG_HOLD_CYCLES; hold++) @(posedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_token(logic [OP_W-1:0] t_op, logic [DATA_W-1:0] t_val, logic t_last);
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= t_op;
    value <= t_val;
    last <= t_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tokens_sent++;
  endtask

  function automatic logic [DATA_W-1:0] random_operand();
    case ($urandom_range(0, 7))
      0: return MAX_POS;
      1: return MIN_NEG;
      2: return MINUS_ONE;
      3: return '0;
      4, 5: return $urandom_range(0, 40) - 20;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_expression();
    int operands, depth, left, i;
    if ($urandom_range(0, 19) == 0) begin
      // deep stack: from two below full to one past
      operands = $urandom_range(14, DEPTH + 1);
      for (i = 0; i < operands; i++) send_token(OP_PUSH, random_operand(), 1'b0);
      for (i = 0; i < operands - 1; i++)
        send_token(OP_W'($urandom_range(OP_ADD, OP_DIV)), $urandom(), i == operands - 2);
    end else begin
      operands = $urandom_range(1, 8);
      depth = 0;
      left = operands;
      while (left > 0 || depth > 1) begin
        if ($urandom_range(0, 24) == 0)
          send_token(OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), $urandom(), 1'b0);
        if (left > 0 && (depth < 2 || $urandom_range(0, 1) == 1)) begin
          left--;
          depth++;
          send_token(OP_PUSH, random_operand(), left == 0 && depth == 1);
        end else begin
          depth--;
          send_token(OP_W'($urandom_range(OP_ADD, OP_DIV)), $urandom(),
                     left == 0 && depth == 1);
        end
      end
    end
  endtask

  task automatic send_noise();
    int n, i;
    logic [OP_W-1:0] t_op;
    n = $urandom_range(1, 6);
    for (i = 0; i < n; i++) begin
      t_op = OP_W'($urandom_range(OP_PUSH, OP_UNUSED_HI));
      send_token(t_op, (t_op == OP_PUSH) ? random_operand() : $urandom(), i == n - 1);
    end
  endtask

  task automatic test_directed();
    // wrap on add, most negative over minus one, sub and mul wrap
    send_token(OP_PUSH, MAX_POS, 1'b0);
    send_token(OP_PUSH, 32'd1, 1'b0);
    send_token(OP_ADD, MINUS_ONE, 1'b0);
    send_token(OP_PUSH, MINUS_ONE, 1'b0);
    send_token(OP_DIV, '0, 1'b0);
    send_token(OP_PUSH, 32'd2, 1'b0);
    send_token(OP_SUB, '0, 1'b0);
    send_token(OP_PUSH, 32'hffff_fffd, 1'b0);
    send_token(OP_MUL, MAX_POS, 1'b1);
    // truncation toward zero
    send_token(OP_PUSH, 32'hffff_fff9, 1'b0);
    send_token(OP_PUSH, 32'd2, 1'b0);
    send_token(OP_DIV, '0, 1'b1);
    // divide by zero stays sticky
    send_token(OP_PUSH, 32'd5, 1'b0);
    send_token(OP_PUSH, '0, 1'b0);
    send_token(OP_DIV, '0, 1'b0);
    send_token(OP_PUSH, 32'd1, 1'b0);
    send_token(OP_ADD, '0, 1'b1);
    // too few operands
    send_token(OP_ADD, '0, 1'b1);
    // bad depth with an ignored code in between
    send_token(OP_PUSH, 32'd1, 1'b0);
    send_token(OP_UNUSED_MID, MIN_NEG, 1'b0);
    send_token(OP_PUSH, 32'd2, 1'b1);
    // ignored code ends an empty expression
    send_token(OP_UNUSED_HI, MINUS_ONE, 1'b1);
  endtask

  task automatic test_overflow();
    int i;
    for (i = 0; i <= DEPTH; i++) send_token(OP_PUSH, $urandom(), 1'b0);
    send_token(OP_MUL, '0, 1'b1);
  endtask

  task automatic test_random(int budget);
    int stop_at;
    stop_at = tokens_sent + budget;
    while (tokens_sent < stop_at) begin
      if ($urandom_range(0, 6) == 0) send_noise();
      else send_expression();
    end
  endtask

  task automatic test_output_backpressure();
    long_hold = 1'b1;
    repeat (6) begin
      send_token(OP_PUSH, random_operand(), 1'b0);
      send_token(OP_PUSH, random_operand(), 1'b0);
      send_token(OP_W'($urandom_range(OP_ADD, OP_DIV)), $urandom(), 1'b1);
    end
  endtask

  task automatic test_drain_pause();
    in_valid <= 1'b0;
    wait (expected_results.size() == 0);
    @(posedge clk);
  endtask

  initial begin : stimulus
    rst = 1'b1;
    in_valid = 1'b0;
    op = OP_PUSH;
    value = '0;
    last = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_overflow();
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
    test_random(800);
    test_output_backpressure();
    test_drain_pause();
    test_random(650);
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    test_random(350);
    in_valid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (60) @(posedge clk);
    $display("%0d tokens evaluated, %0d results checked", tokens_sent, results_seen);
    $display("status counts: ok %0d, too few %0d, div by zero %0d, bad depth %0d, overflow %0d",
             status_hits[ST_OK], status_hits[ST_FEW], status_hits[ST_DIVZERO],
             status_hits[ST_DEPTH], status_hits[ST_OVERFLOW]);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("rpn_stack_evaluator_tb OK");
    end else begin
      $display("rpn_stack_evaluator_tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("rpn_stack_evaluator_tb NOT OK");
    $finish;
  end

endmodule

@@ rpn_stack_evaluator.f @@
sv/rse_pkg.sv
sv/rpn_stack_evaluator.sv
tb/rpn_stack_evaluator_tb.sv
